>>> design/assert_macros.svh
// assertion macros shared by the design files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/itt_pkg.sv
// package with constants and types of the interval timer table
package itt_pkg;

  localparam int unsigned NUM_SLOTS = 16;
  localparam int unsigned SLOT_W    = 8;
  localparam int unsigned PERIOD_W  = 16;
  localparam int unsigned IDX_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  localparam logic FUNC_TICK  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  typedef struct packed {
    logic [PERIOD_W-1:0] period;
    logic [PERIOD_W-1:0] stamp;
  } itt_entry_t;

  localparam int unsigned ENTRY_W = $bits(itt_entry_t);

endpackage

>>> design/itt_if.sv
// handshake interfaces for the query and result channels
interface itt_in_if
  import itt_pkg::*;
();
  logic                valid;
  logic                ready;
  logic                func;
  logic [SLOT_W-1:0]   slot;
  logic [PERIOD_W-1:0] period_ms;

  modport source (output valid, output func, output slot, output period_ms, input ready);
  modport sink   (input valid, input func, input slot, input period_ms, output ready);
endinterface

interface itt_out_if;
  logic valid;
  logic ready;
  logic elapsed;
  logic slot_bad;

  modport source (output valid, output elapsed, output slot_bad, input ready);
  modport sink   (input valid, input elapsed, input slot_bad, output ready);
endinterface

>>> design/itt_ram.sv
// simple dual-port synchronous ram with registered read data
module itt_ram #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 32,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/interval_timer_table.sv
// Interval timer table: one shared 16-bit millisecond counter and NUM_SLOTS periodic
// timers whose period and reference stamp sit in one synchronous ram. A tick
// transaction advances the counter. A query transaction reads the slot entry at
// acceptance; in the evaluate state that follows, it is evaluated and, if the period
// changed or has elapsed, written back, and the result register is loaded. No new
// transaction is accepted in the evaluate state, which is held while a previous result
// is still waiting to be taken. Per-slot valid flops, cleared by reset, make a never
// written entry read as zero period and zero stamp, so no clearing pass is needed.
module interval_timer_table
  import itt_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  itt_in_if.sink    in_i,
  itt_out_if.source out_o
);

`include "assert_macros.svh"

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EVAL = 1'b1;

  logic                 state_q, state_d;
  logic [PERIOD_W-1:0]  ms_count_q;
  logic [NUM_SLOTS-1:0] vld_q;
  logic                 hit_q;
  logic                 bad_q;
  logic [IDX_W-1:0]     idx_q;
  logic [PERIOD_W-1:0]  period_q;
  logic                 out_valid_q;
  logic                 elapsed_q;
  logic                 slot_bad_q;

  logic                 in_acc;
  logic                 tick_acc;
  logic                 query_acc;
  logic                 slot_bad;
  logic [IDX_W-1:0]     in_idx;
  logic                 out_free;
  logic                 eval_go;
  logic [ENTRY_W-1:0]   rd_data;
  itt_entry_t           ent;
  itt_entry_t           wr_ent;
  logic [PERIOD_W-1:0]  diff;
  logic                 ram_we;
  logic                 elapsed;

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign tick_acc   = in_acc && (in_i.func == FUNC_TICK);
  assign query_acc  = in_acc && (in_i.func == FUNC_QUERY);
  assign slot_bad   = {1'b0, in_i.slot} >= 9'(NUM_SLOTS);
  assign in_idx     = IDX_W'(in_i.slot);

  assign out_free = !out_valid_q || out_o.ready;
  assign eval_go  = (state_q == ST_EVAL) && out_free;

  itt_ram #(
    .DEPTH (NUM_SLOTS),
    .WIDTH (ENTRY_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (idx_q),
    .wdata_i (wr_ent),
    .re_i    (query_acc),
    .raddr_i (in_idx),
    .rdata_o (rd_data)
  );

  // entry never written reads as zero
  assign ent  = hit_q ? itt_entry_t'(rd_data) : '0;
  assign diff = ms_count_q - ent.stamp;

  always_comb begin
    ram_we        = 1'b0;
    elapsed       = 1'b0;
    wr_ent.period = period_q;
    wr_ent.stamp  = ms_count_q;
    if (eval_go && !bad_q) begin
      if (ent.period != period_q) begin
        ram_we = 1'b1;
      end else if (diff >= period_q) begin
        ram_we  = 1'b1;
        elapsed = 1'b1;
      end
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (query_acc) begin
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ms_count_q  <= '0;
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (tick_acc) begin
        ms_count_q <= ms_count_q + PERIOD_W'(1);
      end
      if (ram_we) begin
        vld_q[idx_q] <= 1'b1;
      end
      if (eval_go) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (query_acc) begin
      hit_q    <= vld_q[in_idx] && !slot_bad;
      bad_q    <= slot_bad;
      idx_q    <= in_idx;
      period_q <= in_i.period_ms;
    end
    if (eval_go) begin
      elapsed_q  <= elapsed;
      slot_bad_q <= bad_q;
    end
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.elapsed  = elapsed_q;
  assign out_o.slot_bad = slot_bad_q;

  `ASSERT_NEXT(a_query_to_eval, clk_i, rst_ni, query_acc, state_q == ST_EVAL, "query not evaluated")
  `ASSERT_SAME(a_no_bad_write, clk_i, rst_ni, ram_we, !bad_q && (state_q == ST_EVAL), "bad write")
  `ASSERT_NEXT(a_count_hold, clk_i, rst_ni, !tick_acc, $stable(ms_count_q), "counter moved")
  `ASSERT_SAME(a_result_src, clk_i, rst_ni, $rose(out_valid_q), $past(state_q == ST_EVAL), "stray result")
  `ASSERT_SAME(a_bad_not_elapsed, clk_i, rst_ni, out_valid_q && slot_bad_q, !elapsed_q, "bad elapsed")

endmodule
